### rtl/core/plrs_pkg.sv
// Package with shared types and codes for the positional list with range sort.
`default_nettype none

package plrs_pkg;

    // Action codes carried on the input tuser
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_SORT   = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    // Result status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ERASE  = 2'd2,
        CELL_SORT   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;   // odd-even transposition phase
    } cell_ctrl_t;

    // Stream payload widths
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;

endpackage

`default_nettype wire

### rtl/core/plrs_cell.sv
// One list cell: holds an entry, shifts with neighbors, does compare-exchange.
`default_nettype none

module plrs_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6
) (
    input  wire logic                clk,
    input  wire plrs_pkg::cell_ctrl_t ctrl,
    input  wire logic [IW-1:0]       pos,
    input  wire logic [IW-1:0]       first,
    input  wire logic [IW-1:0]       last,
    input  wire logic [31:0]         value_in,
    input  wire logic [31:0]         left_value,
    input  wire logic [31:0]         right_value,
    output logic [31:0]              value,
    output logic [31:0]              tap
);
    import plrs_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [31:0] value_reg;
    logic [31:0] value_next;
    logic        pair_lo;
    logic        pair_hi;

    // lower / upper member of an active compare-exchange pair
    assign pair_lo = (MY_IDX >= first) && (MY_IDX < last) && (MY_IDX[0] == ctrl.phase);
    assign pair_hi = (MY_IDX > first) && (MY_IDX <= last) && (MY_IDX[0] != ctrl.phase);

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (MY_IDX == pos)
                begin
                    value_next = value_in;
                end
                else if (MY_IDX > pos)
                begin
                    value_next = left_value;
                end
            end
            CELL_ERASE:
            begin
                if (MY_IDX >= pos)
                begin
                    value_next = right_value;
                end
            end
            CELL_SORT:
            begin
                if (pair_lo && ($signed(value_reg) > $signed(right_value)))
                begin
                    value_next = right_value;
                end
                else if (pair_hi && ($signed(left_value) > $signed(value_reg)))
                begin
                    value_next = left_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign tap   = (MY_IDX == pos) ? value_reg : 32'd0;

endmodule

`default_nettype wire

### rtl/core/positional_list_with_range_sort.sv
// Top level: positional list of signed values with insert, erase and range sort.
//
// Channel  Dir  Signals                          Meaning
// s        in   s_tvalid s_tready s_tdata s_tuser  one action per transaction
// m        out  m_tvalid m_tready m_tdata          one result per action
//
// Insert, erase and query results are registered and appear in the cycle after accept.
// A range sort runs (range_last - range_first + 1) odd-even transposition
// passes over the cell chain, one pass per cycle, and then posts the result
// from S_FINISH once the output register is free.
// Reset clears the entry count, FSM and output valid; cell contents are
// not reset and are only read below the count.
// A stalled result holds in the output register; a new action is taken in
// the same cycle the pending result leaves.
`default_nettype none

module positional_list_with_range_sort #(
    parameter int CAPACITY = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // s_tdata from bit 0: item_value[31:0], position[38:32],
    // range_first[44:39], range_last[50:45], zero pad[55:51]
    input  wire logic [plrs_pkg::IN_DATA_W-1:0] s_tdata,
    // s_tuser from bit 0: action[1:0]
    input  wire logic [plrs_pkg::IN_USER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata from bit 0: removed_value[31:0], status[33:32],
    // entry_count[40:34], list_empty[41], zero pad[47:42]
    output logic [plrs_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import plrs_pkg::*;

    localparam int IW = $clog2(CAPACITY);       // cell index width
    localparam int CW = $clog2(CAPACITY + 1);   // count width
    localparam int XW = (CW > 7) ? CW : 7;      // compare width
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SORT,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [IW-1:0]         first_reg, first_next;
    logic [IW-1:0]         last_reg, last_next;
    logic [IW-1:0]         rem_reg, rem_next;
    logic                  phase_reg, phase_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // input fields
    action_t       action;
    logic [31:0]   item_value;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] first_x;
    logic [XW-1:0] last_x;
    logic [XW-1:0] cnt_x;

    assign action     = action_t'(s_tuser[1:0]);
    assign item_value = s_tdata[31:0];
    assign pos_x      = XW'(s_tdata[38:32]);
    assign first_x    = XW'(s_tdata[44:39]);
    assign last_x     = XW'(s_tdata[50:45]);
    assign cnt_x      = XW'(count_reg);

    logic       out_free;
    logic       in_fire;
    cell_ctrl_t ctrl;
    logic [IW-1:0] cell_pos;

    logic [31:0] cell_value [CAPACITY];
    logic [31:0] cell_tap   [CAPACITY];
    logic [31:0] removed;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;

    // empty list: insert lands at the head whatever position was given
    assign cell_pos = (cnt_x == '0) ? '0 : IW'(pos_x);

    // OR of one-hot taps gives the entry at the erase position
    always_comb
    begin
        removed = 32'd0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            removed = removed | cell_tap[i];
        end
    end

    function automatic logic [OUT_DATA_W-1:0] pack_result(
        input logic [31:0]   rem_val,
        input logic [1:0]    st,
        input logic [CW-1:0] cnt
    );
        logic [XW-1:0] cnt_w;
        cnt_w = XW'(cnt);
        return {6'd0, (cnt == '0), cnt_w[6:0], st, rem_val};
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        rem_next     = rem_reg;
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        ctrl.op      = CELL_HOLD;
        ctrl.phase   = phase_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = pack_result(32'd0, ST_DONE, count_reg);
                    case (action)
                        ACT_INSERT:
                        begin
                            if (cnt_x >= CAP_X)
                            begin
                                m_data_next = pack_result(32'd0, ST_FULL, count_reg);
                            end
                            else if (cnt_x == '0)
                            begin
                                ctrl.op    = CELL_INSERT;
                                count_next = count_reg + 1'b1;
                                m_data_next = pack_result(32'd0, ST_DONE, count_next);
                            end
                            else if (pos_x > cnt_x)
                            begin
                                m_data_next = pack_result(32'd0, ST_BAD, count_reg);
                            end
                            else
                            begin
                                ctrl.op    = CELL_INSERT;
                                count_next = count_reg + 1'b1;
                                m_data_next = pack_result(32'd0, ST_DONE, count_next);
                            end
                        end
                        ACT_ERASE:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                m_data_next = pack_result(32'd0, ST_BAD, count_reg);
                            end
                            else
                            begin
                                ctrl.op    = CELL_ERASE;
                                count_next = count_reg - 1'b1;
                                m_data_next = pack_result(removed, ST_DONE, count_next);
                            end
                        end
                        ACT_SORT:
                        begin
                            if (last_x >= cnt_x)
                            begin
                                m_data_next = pack_result(32'd0, ST_BAD, count_reg);
                            end
                            else if (first_x < last_x)
                            begin
                                // result posted when the passes finish
                                m_valid_next = 1'b0;
                                first_next   = IW'(first_x);
                                last_next    = IW'(last_x);
                                rem_next     = IW'(last_x - first_x);
                                phase_next   = 1'b0;
                                state_next   = S_SORT;
                            end
                        end
                        default:
                        begin
                            m_data_next = pack_result(32'd0, ST_DONE, count_reg);
                        end
                    endcase
                end
            end
            S_SORT:
            begin
                ctrl.op    = CELL_SORT;
                phase_next = !phase_reg;
                if (rem_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    rem_next = rem_reg - 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = pack_result(32'd0, ST_DONE, count_reg);
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
            rem_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
            rem_reg     <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
    end

    // cell chain; ends are tied to zero
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [31:0] left_v;
        logic [31:0] right_v;

        if (g == 0)
        begin : g_lo
            assign left_v = 32'd0;
        end
        else
        begin : g_lo
            assign left_v = cell_value[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_hi
            assign right_v = 32'd0;
        end
        else
        begin : g_hi
            assign right_v = cell_value[g+1];
        end

        plrs_cell #(
            .IDX (g),
            .IW  (IW)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .pos         (state_reg == S_IDLE ? cell_pos : '0),
            .first       (first_reg),
            .last        (last_reg),
            .value_in    (item_value),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[g]),
            .tap         (cell_tap[g])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == S_IDLE))
        else $error("ready outside idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (XW'(count_reg) <= CAP_X))
        else $error("count above capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[41] == (m_tdata[40:34] == 7'd0)))
        else $error("empty flag disagrees with count");

    a_sort_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (action == ACT_SORT)) |=> (count_reg == $past(count_reg)))
        else $error("sort changed count");

    a_sort_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SORT) |=> !(m_tvalid && !$past(m_tvalid)))
        else $error("result posted during sort passes");
`endif

endmodule

`default_nettype wire
